/* hw/rtl/bgtf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Background tile fetcher package
// Word layouts, register indexes and constants shared by the fetcher files.
// ----------------------------------------------------------------------------
package bgtf_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 16;
    localparam int PIXELS_PER_ROW     = 8;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_LCD_CONTROL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_X     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_Y     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE0     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE1     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE2     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE3     = 3'd6;

    localparam logic [7:0]  TILE_BIAS      = 8'd128;
    localparam logic [15:0] DATA_BASE_LOW  = 16'h8000;
    localparam logic [15:0] DATA_BASE_HIGH = 16'h8800;
    localparam logic [4:0]  MAP_PREFIX     = 5'b10011;

    typedef struct packed {
        logic       req_type;
        logic [7:0] scan_line;
        logic       odd_dot;
        logic [7:0] read_data;
    } dot_word_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  pixel_x;
        logic [31:0] pixel_color;
        logic        read_valid;
        logic [15:0] read_addr;
    } result_word_t;

endpackage
`default_nettype wire

/* hw/rtl/bgtf_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fetcher stream channel
// Valid/ready channel carrying one word per accepted handshake.
// ----------------------------------------------------------------------------
interface bgtf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bg_tile_fetcher_pixel_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Background tile fetcher and pixel FIFO
// Fetches background tile rows from video memory and shifts pixels out.
// ----------------------------------------------------------------------------
// One dot word is accepted every clock cycle while the skid stage is empty;
// its result goes to the output register, or to the skid register when the
// output is held. A register plus skid stage on the result side keeps the
// input ready while one result waits. The pixel row memory head row is read
// from the next head index, forwarding a row written in the same cycle.
// The memory holds whole rows of eight pixels and needs no clearing after reset.
module bg_tile_fetcher_pixel_fifo
    import bgtf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    bgtf_stream_if.sink                 dot,
    bgtf_stream_if.source               result
);

    localparam int ROW_COUNT = FIFO_DEPTH / PIXELS_PER_ROW;
    localparam int ROW_W     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ROW_BITS  = 2 * PIXELS_PER_ROW;

    typedef enum logic [2:0] {
        PH_TILE,
        PH_LOW,
        PH_HIGH,
        PH_IDLE,
        PH_PUSH
    } phase_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_TILE,
        PEND_LOW,
        PEND_HIGH
    } pend_t;

    function automatic logic [ROW_W-1:0] row_incr(input logic [ROW_W-1:0] r);
        logic [ROW_W-1:0] n;
        if (r == ROW_W'(ROW_COUNT - 1))
        begin
            n = '0;
        end
        else
        begin
            n = r + 1'b1;
        end
        return n;
    endfunction

    logic [7:0]  lcd_control_reg;
    logic [7:0]  scroll_x_reg;
    logic [7:0]  scroll_y_reg;
    logic [31:0] palette_reg [4];

    phase_t           fetch_phase_reg, fetch_phase_next;
    logic [8:0]       fetch_column_reg, fetch_column_next;
    logic [7:0]       tile_number_reg, tile_number_next;
    logic [7:0]       plane_low_reg, plane_low_next;
    logic [7:0]       plane_high_reg, plane_high_next;
    pend_t            pending_reg, pending_next;
    logic [ROW_W-1:0] head_row_reg, head_row_next;
    logic [2:0]       head_off_reg, head_off_next;
    logic [ROW_W-1:0] tail_row_reg, tail_row_next;
    logic [4:0]       store_count_reg, store_count_next;
    logic [7:0]       shifted_out_reg, shifted_out_next;
    logic [7:0]       emitted_count_reg, emitted_count_next;

    logic [ROW_BITS-1:0] row_mem [ROW_COUNT];
    logic [ROW_BITS-1:0] head_data_reg;
    logic [ROW_BITS-1:0] push_row;
    logic                push_en;

    logic         out_valid_reg, skid_valid_reg;
    result_word_t out_data_reg, skid_data_reg;
    result_word_t res_word;

    logic        in_fire, out_free;
    logic [7:0]  map_x, map_y;
    logic [15:0] data_base;
    logic [15:0] data_addr;
    logic [4:0]  count_mid;
    logic [1:0]  pop_idx;

    assign in_fire  = dot.valid && dot.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign dot.ready    = !skid_valid_reg;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    assign map_x     = fetch_column_reg[7:0] + scroll_x_reg;
    assign map_y     = dot.data.scan_line + scroll_y_reg;
    assign data_base = lcd_control_reg[4] ? DATA_BASE_LOW : DATA_BASE_HIGH;
    assign pop_idx   = head_data_reg[{head_off_reg, 1'b0} +: 2];

    always_comb
    begin
        for (int p = 0; p < PIXELS_PER_ROW; p++)
        begin
            push_row[2*p +: 2] = {plane_high_next[PIXELS_PER_ROW-1-p],
                                  plane_low_next[PIXELS_PER_ROW-1-p]};
        end
    end

    always_comb
    begin
        fetch_phase_next   = fetch_phase_reg;
        fetch_column_next  = fetch_column_reg;
        tile_number_next   = tile_number_reg;
        plane_low_next     = plane_low_reg;
        plane_high_next    = plane_high_reg;
        pending_next       = pending_reg;
        head_row_next      = head_row_reg;
        head_off_next      = head_off_reg;
        tail_row_next      = tail_row_reg;
        store_count_next   = store_count_reg;
        shifted_out_next   = shifted_out_reg;
        emitted_count_next = emitted_count_reg;
        push_en            = 1'b0;
        count_mid          = store_count_reg;
        data_addr          = '0;
        res_word           = '0;

        if (in_fire && dot.data.req_type)
        begin
            fetch_phase_next   = PH_TILE;
            fetch_column_next  = '0;
            pending_next       = PEND_NONE;
            head_row_next      = '0;
            head_off_next      = '0;
            tail_row_next      = '0;
            store_count_next   = '0;
            shifted_out_next   = '0;
            emitted_count_next = '0;
        end
        else if (in_fire)
        begin
            // The byte requested on the previous dot lands before the fetcher runs.
            unique case (pending_reg)
                PEND_TILE:
                begin
                    tile_number_next = lcd_control_reg[4] ? dot.data.read_data
                                     : 8'(dot.data.read_data + TILE_BIAS);
                end
                PEND_LOW:  plane_low_next = dot.data.read_data;
                PEND_HIGH: plane_high_next = dot.data.read_data;
                default:   ;
            endcase
            pending_next = PEND_NONE;
            data_addr    = data_base + {4'b0, tile_number_next, 4'b0}
                         + {12'b0, map_y[2:0], 1'b0};

            if (!dot.data.odd_dot)
            begin
                unique case (fetch_phase_reg)
                    PH_LOW:
                    begin
                        res_word.read_valid = 1'b1;
                        res_word.read_addr  = data_addr;
                        pending_next        = PEND_LOW;
                        fetch_phase_next    = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        res_word.read_valid = 1'b1;
                        res_word.read_addr  = data_addr | 16'd1;
                        pending_next        = PEND_HIGH;
                        fetch_phase_next    = PH_IDLE;
                    end
                    PH_IDLE:
                    begin
                        fetch_phase_next = PH_PUSH;
                    end
                    PH_PUSH:
                    begin
                        if (store_count_reg <= 5'd8)
                        begin
                            // Rows left of the visible area after a column wrap are dropped.
                            if ({1'b0, fetch_column_reg} + {7'b0, scroll_x_reg[2:0]}
                                >= 10'd8)
                            begin
                                push_en       = 1'b1;
                                tail_row_next = row_incr(tail_row_reg);
                            end
                            fetch_phase_next = PH_TILE;
                        end
                    end
                    default:
                    begin
                        if (lcd_control_reg[0])
                        begin
                            res_word.read_valid = 1'b1;
                            res_word.read_addr  = {MAP_PREFIX, lcd_control_reg[3],
                                                   map_y[7:3], map_x[7:3]};
                            pending_next        = PEND_TILE;
                        end
                        fetch_phase_next  = PH_LOW;
                        fetch_column_next = fetch_column_reg + 9'd8;
                    end
                endcase
            end

            count_mid = store_count_reg + (push_en ? 5'd8 : 5'd0);
            if (count_mid > 5'd8)
            begin
                store_count_next = count_mid - 5'd1;
                head_off_next    = head_off_reg + 3'd1;
                if (head_off_reg == 3'd7)
                begin
                    head_row_next = row_incr(head_row_reg);
                end
                if (shifted_out_reg >= {5'b0, scroll_x_reg[2:0]})
                begin
                    res_word.pixel_valid = 1'b1;
                    res_word.pixel_x     = emitted_count_reg;
                    res_word.pixel_color = palette_reg[pop_idx];
                    emitted_count_next   = emitted_count_reg + 8'd1;
                end
                shifted_out_next = shifted_out_reg + 8'd1;
            end
            else
            begin
                store_count_next = count_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_control_reg <= '0;
            scroll_x_reg    <= '0;
            scroll_y_reg    <= '0;
            for (int i = 0; i < 4; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LCD_CONTROL: lcd_control_reg <= cfg_data[7:0];
                CFG_SCROLL_X:    scroll_x_reg <= cfg_data[7:0];
                CFG_SCROLL_Y:    scroll_y_reg <= cfg_data[7:0];
                CFG_PALETTE0:    palette_reg[0] <= cfg_data;
                CFG_PALETTE1:    palette_reg[1] <= cfg_data;
                CFG_PALETTE2:    palette_reg[2] <= cfg_data;
                CFG_PALETTE3:    palette_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_phase_reg   <= PH_TILE;
            fetch_column_reg  <= '0;
            tile_number_reg   <= '0;
            plane_low_reg     <= '0;
            plane_high_reg    <= '0;
            pending_reg       <= PEND_NONE;
            head_row_reg      <= '0;
            head_off_reg      <= '0;
            tail_row_reg      <= '0;
            store_count_reg   <= '0;
            shifted_out_reg   <= '0;
            emitted_count_reg <= '0;
        end
        else
        begin
            fetch_phase_reg   <= fetch_phase_next;
            fetch_column_reg  <= fetch_column_next;
            tile_number_reg   <= tile_number_next;
            plane_low_reg     <= plane_low_next;
            plane_high_reg    <= plane_high_next;
            pending_reg       <= pending_next;
            head_row_reg      <= head_row_next;
            head_off_reg      <= head_off_next;
            tail_row_reg      <= tail_row_next;
            store_count_reg   <= store_count_next;
            shifted_out_reg   <= shifted_out_next;
            emitted_count_reg <= emitted_count_next;
        end
    end

    // The head row is read from the next head index; a row written now is forwarded.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            row_mem[tail_row_reg] <= push_row;
        end
        if (push_en && (tail_row_reg == head_row_next))
        begin
            head_data_reg <= push_row;
        end
        else
        begin
            head_data_reg <= row_mem[head_row_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_fire)
            begin
                out_data_reg <= res_word;
            end
        end
        else if (in_fire)
        begin
            skid_data_reg <= res_word;
        end
    end

endmodule
`default_nettype wire
